// File: rtl/gf256_arithmetic_unit_assert.svh
// Assertion macros shared by the GF(2^8) unit.
// GFAU_ASSERT holds a property on every edge outside reset.
// GFAU_ASSERT_NEVER flags a condition that must never be seen.
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GFAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gfau assertion failed");
`define GFAU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gfau forbidden condition seen");
`else
`define GFAU_ASSERT(lbl, clk, rstn, prop)
`define GFAU_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: rtl/gfau_pkg.sv
package gfau_pkg;

  // reduction term of x^8+x^4+x^3+x+1 once bit 7 shifts out
  localparam logic [7:0] GfReduce  = 8'h1b;
  localparam logic [7:0] GfHighBit = 8'h80;
  localparam int unsigned GfBits   = 8;

  // positive exponents fit in 15 bits; bit 15 is the sign
  localparam int unsigned ExpW = 15;
  localparam logic [ExpW-1:0] InvExp = 15'd254;  // a^254 = a^-1

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_INV = 2'd2,
    OP_POW = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic load;   // take a new request into the datapath
    logic step;   // one square-and-multiply iteration
    logic emit;   // copy the accumulator to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;  // no exponent bits left
  } dp_sts_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < GfBits; k++) begin
      if (b[k]) acc = acc ^ x;
      if ((x & GfHighBit) != 8'h00) x = {x[6:0], 1'b0} ^ GfReduce;
      else x = {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// File: rtl/gfau_req_if.sv
interface gfau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         operand_a;
  logic [7:0]         operand_b;
  logic signed [15:0] exponent;

  modport source (output valid, req_type, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, exponent, output ready);
endinterface

// File: rtl/gfau_rsp_if.sv
interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// File: rtl/gfau_datapath.sv
module gfau_datapath (
  input  logic               clk_i,
  input  gfau_pkg::dp_cmd_t  cmd_i,
  output gfau_pkg::dp_sts_t  sts_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         operand_a_i,
  input  logic [7:0]         operand_b_i,
  input  logic signed [15:0] exponent_i,
  output logic [7:0]         result_o
);

  logic [7:0]                acc_q, acc_d;
  logic [7:0]                sq_q, sq_d;
  logic [gfau_pkg::ExpW-1:0] exp_q, exp_d;
  logic [7:0]                res_q, res_d;
  gfau_pkg::req_type_e       op;

  assign op = gfau_pkg::req_type_e'(req_type_i);

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    res_d = res_q;
    if (cmd_i.load) begin
      acc_d = 8'h01;
      sq_d  = operand_a_i;
      exp_d = '0;
      case (op)
        gfau_pkg::OP_ADD: acc_d = operand_a_i ^ operand_b_i;
        gfau_pkg::OP_MUL: acc_d = gfau_pkg::gf_mul(operand_a_i, operand_b_i);
        gfau_pkg::OP_INV: exp_d = gfau_pkg::InvExp;
        gfau_pkg::OP_POW: begin
          // zero or negative exponent leaves exp at 0: result 1
          if (!exponent_i[15]) exp_d = exponent_i[gfau_pkg::ExpW-1:0];
        end
        default: acc_d = 8'h01;
      endcase
    end else if (cmd_i.step) begin
      if (exp_q[0]) acc_d = gfau_pkg::gf_mul(acc_q, sq_q);
      sq_d  = gfau_pkg::gf_mul(sq_q, sq_q);
      exp_d = exp_q >> 1;
    end
    if (cmd_i.emit) res_d = acc_q;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  assign sts_o.exp_zero = (exp_q == '0);
  assign result_o       = res_q;

endmodule

// File: rtl/gfau_ctrl.sv
`include "gf256_arithmetic_unit_assert.svh"

module gfau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gfau_pkg::dp_cmd_t cmd_o,
  input  gfau_pkg::dp_sts_t sts_i
);

  gfau_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gfau_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gfau_pkg::ST_RUN;
      end
      gfau_pkg::ST_RUN: begin
        if (sts_i.exp_zero && out_free) state_d = gfau_pkg::ST_IDLE;
      end
      default: state_d = gfau_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      gfau_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gfau_pkg::ST_RUN: begin
        cmd_o.step = !sts_i.exp_zero;
        cmd_o.emit = sts_i.exp_zero && out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfau_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `GFAU_ASSERT(a_accept_runs, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == gfau_pkg::ST_RUN))
  `GFAU_ASSERT_NEVER(a_emit_early, clk_i, rst_ni, cmd_o.emit && !sts_i.exp_zero)
  `GFAU_ASSERT_NEVER(a_step_and_emit, clk_i, rst_ni, cmd_o.step && cmd_o.emit)
  `GFAU_ASSERT(a_finish, clk_i, rst_ni, cmd_o.emit |=> (out_valid_q && state_q == gfau_pkg::ST_IDLE))

endmodule

// File: rtl/gf256_arithmetic_unit.sv
// Channel | Dir | Payload                                   | Role
// req     | in  | req_type, operand_a, operand_b, exponent  | one operation per beat
// rsp     | out | result                                    | one byte per request beat
//
// Add and multiply are computed at load and pass to the result register on emit.
// Power steps once per bit of the exponent's bit length; inverse runs a^254
// the same way. One exponent bit per cycle through the square-and-multiply
// loop; one request is in flight at a time.
// Reset (rst_ni, async, active low) clears the controller and the result valid.
// A pending result does not block the next request; only its completion waits
// until the result register is free.
module gf256_arithmetic_unit (
  input logic        clk_i,
  input logic        rst_ni,
  gfau_req_if.sink   req,
  gfau_rsp_if.source rsp
);

  gfau_pkg::dp_cmd_t cmd;
  gfau_pkg::dp_sts_t sts;

  // controller: handshakes and sequencing
  gfau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: operand registers, three GF multipliers (a*b at load, acc*sq and
  // sq*sq per step), result
  gfau_datapath u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req.req_type),
    .operand_a_i (req.operand_a),
    .operand_b_i (req.operand_b),
    .exponent_i  (req.exponent),
    .result_o    (rsp.result)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the GF(2^8) arithmetic unit.
// A directed table of corner cases is followed by random requests. Each request beat
// that is taken by the unit gets a predicted result byte. Each response beat is compared
// with the oldest prediction in order.
module testbench;

  localparam int DirN          = 25;
  localparam int RandBlocks    = 17;
  localparam int BlockItems    = 100;
  localparam int PressureBlock = 8;
  localparam int HoldCycles    = 400;   // long receiver hold-off, fills the unit
  localparam int DrainCycles   = 40;    // stray-beat window after the last predicted result
  localparam int IdleLimit     = 2000;  // cycles with no beat on either side

  // One request, plus the result where it is obvious enough to type in
  typedef struct packed {
    gfau_pkg::req_type_e op;
    logic [7:0]          a;
    logic [7:0]          b;
    logic signed [15:0]  e;
    logic                pinned;
    logic [7:0]          want;
  } gf_req_t;

  typedef struct packed {
    logic       pinned;
    logic [7:0] want;
  } pin_t;

  typedef struct packed {
    gfau_pkg::req_type_e op;
    logic [7:0]          value;
  } gf_result_t;

  logic clk;
  logic rst_n;

  gfau_req_if req_bus ();
  gfau_rsp_if rsp_bus ();

  gf256_arithmetic_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  gf_req_t    dir_rows [DirN];
  pin_t       pin_q [$];          // typed-in results, one entry per offered beat
  gf_result_t pending_results [$];

  bit burst_mode;                 // no idling on either side
  bit hold_rsp;                   // asks the receiver for one long hold-off
  int mismatches;
  int results_checked;
  int pinned_checked;
  int op_count [4];
  int hold_stretches;

  // -------------------------------------------------------------------------
  // Clock and reset
  // -------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Field arithmetic
  // -------------------------------------------------------------------------
  // Multiply by x, folding in the reduction term when bit 7 drops out
  function automatic logic [7:0] gf_xtime(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ gfau_pkg::GfReduce) : {v[6:0], 1'b0};
  endfunction

  // Horner form, top bit of y first
  function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      acc = gf_xtime(acc);
      if (y[k]) acc = acc ^ x;
    end
    return acc;
  endfunction

  // Left-to-right square-and-multiply over a 15-bit positive exponent
  function automatic logic [7:0] gf_power(input logic [7:0] base, input logic [14:0] ex);
    logic [7:0] acc;
    acc = 8'h01;
    for (int k = 14; k >= 0; k--) begin
      acc = gf_product(acc, acc);
      if (ex[k]) acc = gf_product(acc, base);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_outcome(input gfau_pkg::req_type_e op,
                                            input logic [7:0] a,
                                            input logic [7:0] b,
                                            input logic signed [15:0] e);
    logic [7:0] r;
    case (op)
      gfau_pkg::OP_ADD: r = a ^ b;
      gfau_pkg::OP_MUL: r = gf_product(a, b);
      gfau_pkg::OP_INV: r = gf_power(a, 15'd254);   // a^254, so zero stays zero
      default: begin
        // zero or negative exponent yields one, whatever the base
        if (e == 16'sd0 || e[15]) r = 8'h01;
        else r = gf_power(a, e[14:0]);
      end
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [7:0] draw_byte();
    logic [7:0] v;
    case ($urandom_range(0, 11))
      0:       v = 8'h00;
      1:       v = 8'h01;
      2:       v = 8'hff;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic gf_req_t draw_request();
    gf_req_t r;
    r.op     = gfau_pkg::req_type_e'($urandom_range(0, 3));
    r.a      = draw_byte();
    r.b      = draw_byte();
    r.pinned = 1'b0;
    r.want   = 8'h00;
    case ($urandom_range(0, 9))
      0:       r.e = 16'sd0;
      1:       r.e = 16'($urandom) | 16'h8000;          // negative
      2:       r.e = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      3, 4, 5: r.e = 16'($urandom_range(1, 300));      // short square-and-multiply runs
      default: r.e = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string note);
    $display("[%0t] MISMATCH: %s", $realtime, note);
    mismatches++;
  endtask

  // Offer one request beat. A zero gap leaves valid high across beats.
  task automatic offer(input gf_req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_q.push_back('{pinned: r.pinned, want: r.want});
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= r.op;
    req_bus.operand_a <= r.a;
    req_bus.operand_b <= r.b;
    req_bus.exponent  <= r.e;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random hold-off before every result beat outside burst mode, one long stretch on request
  // -------------------------------------------------------------------------
  initial begin : rsp_sink
    int gap;
    rsp_bus.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        gap      = HoldCycles;
        hold_rsp = 1'b0;
        hold_stretches++;
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // -------------------------------------------------------------------------
  // Scoreboard. Results are checked before the same-edge request is queued, but a
  // result can never belong to a beat taken at the same edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    gf_result_t          head;
    pin_t                pin;
    gfau_pkg::req_type_e op;
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result beat %02h with nothing outstanding",
                                  rsp_bus.result));
        end else begin
          head = pending_results.pop_front();
          results_checked++;
          if (rsp_bus.result !== head.value)
            flag_mismatch($sformatf("%s result %02h, predicted %02h",
                                    head.op.name(), rsp_bus.result, head.value));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        op  = gfau_pkg::req_type_e'(req_bus.req_type);
        pin = pin_q.pop_front();
        op_count[op]++;
        if (pin.pinned) begin
          pinned_checked++;
          pending_results.push_back('{op: op, value: pin.want});
        end else begin
          pending_results.push_back('{op: op,
                                      value: gf_outcome(op, req_bus.operand_a,
                                                        req_bus.operand_b,
                                                        req_bus.exponent)});
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel ends the run
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] timeout: no beat for %0d cycles", $realtime, IdleLimit);
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    // Corner table: identities, extremes, ignored operands, and the one-and-zero cases
    // of inverse and power. Rows with want filled in need no predictor.
    dir_rows = '{
      '{gfau_pkg::OP_ADD, 8'h00, 8'h00, 16'h0000, 1'b1, 8'h00},
      '{gfau_pkg::OP_ADD, 8'hff, 8'hff, 16'h8000, 1'b1, 8'h00},  // exponent is ignored
      '{gfau_pkg::OP_ADD, 8'hff, 8'h00, 16'h7fff, 1'b1, 8'hff},
      '{gfau_pkg::OP_ADD, 8'ha5, 8'h5a, 16'h0000, 1'b1, 8'hff},
      '{gfau_pkg::OP_MUL, 8'h00, 8'hff, 16'h0000, 1'b1, 8'h00},
      '{gfau_pkg::OP_MUL, 8'h01, 8'hff, 16'h0000, 1'b1, 8'hff},
      '{gfau_pkg::OP_MUL, 8'hff, 8'h01, 16'h0000, 1'b1, 8'hff},
      '{gfau_pkg::OP_MUL, 8'h80, 8'h02, 16'h0000, 1'b1, 8'h1b},  // bare reduction term
      '{gfau_pkg::OP_MUL, 8'h57, 8'h83, 16'h0000, 1'b0, 8'h00},
      '{gfau_pkg::OP_MUL, 8'hff, 8'hff, 16'hffff, 1'b0, 8'h00},
      '{gfau_pkg::OP_INV, 8'h00, 8'h00, 16'h0000, 1'b1, 8'h00},  // inverse of zero
      '{gfau_pkg::OP_INV, 8'h01, 8'hff, 16'h8000, 1'b1, 8'h01},  // b and exponent ignored
      '{gfau_pkg::OP_INV, 8'h53, 8'h00, 16'h0000, 1'b0, 8'h00},
      '{gfau_pkg::OP_INV, 8'hff, 8'haa, 16'h0000, 1'b0, 8'h00},
      '{gfau_pkg::OP_POW, 8'h00, 8'h00, 16'h0000, 1'b1, 8'h01},  // zero to the zero
      '{gfau_pkg::OP_POW, 8'h57, 8'hff, 16'h0000, 1'b1, 8'h01},
      '{gfau_pkg::OP_POW, 8'hff, 8'h00, 16'hffff, 1'b1, 8'h01},  // negative exponent
      '{gfau_pkg::OP_POW, 8'h00, 8'h00, 16'h8000, 1'b1, 8'h01},
      '{gfau_pkg::OP_POW, 8'h00, 8'h00, 16'h0005, 1'b1, 8'h00},  // zero base
      '{gfau_pkg::OP_POW, 8'h00, 8'hff, 16'h7fff, 1'b1, 8'h00},
      '{gfau_pkg::OP_POW, 8'h03, 8'h00, 16'h0001, 1'b1, 8'h03},
      '{gfau_pkg::OP_POW, 8'h03, 8'h00, 16'h7fff, 1'b0, 8'h00},  // longest exponent
      '{gfau_pkg::OP_POW, 8'h02, 8'h00, 16'h00ff, 1'b0, 8'h00},
      '{gfau_pkg::OP_POW, 8'hff, 8'h00, 16'h4000, 1'b0, 8'h00},
      '{gfau_pkg::OP_POW, 8'h05, 8'hff, 16'h0002, 1'b0, 8'h00}
    };

    burst_mode = 1'b0;
    hold_rsp   = 1'b0;

    // Known values on every input from time zero
    rst_n             = 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= gfau_pkg::OP_ADD;
    req_bus.operand_a <= 8'h00;
    req_bus.operand_b <= 8'h00;
    req_bus.exponent  <= 16'sd0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirN; i++) offer(dir_rows[i]);

    // Random blocks: every fourth has no idling on either side; one block also holds
    // the receiver off for a long stretch while requests keep coming, so the unit backs up.
    for (int blk = 0; blk < RandBlocks; blk++) begin
      burst_mode = (blk % 4 == 1);
      if (blk == PressureBlock) begin
        burst_mode = 1'b1;
        hold_rsp   = 1'b1;
      end
      for (int n = 0; n < BlockItems; n++) offer(draw_request());
    end
    req_bus.valid <= 1'b0;
    burst_mode = 1'b0;

    // Drain, then give any stray result beat time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived",
                              pending_results.size()));

    $display("Requests: %0d add, %0d multiply, %0d inverse, %0d power (%0d typed)",
             op_count[gfau_pkg::OP_ADD], op_count[gfau_pkg::OP_MUL],
             op_count[gfau_pkg::OP_INV], op_count[gfau_pkg::OP_POW], pinned_checked);
    $display("Results compared: %0d, long receiver hold-offs: %0d, mismatches: %0d",
             results_checked, hold_stretches, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/gfau_pkg.sv
rtl/gfau_req_if.sv
rtl/gfau_rsp_if.sv
rtl/gfau_datapath.sv
rtl/gfau_ctrl.sv
rtl/gf256_arithmetic_unit.sv
tb/sv/testbench.sv
